// ----- hdl/sfcc_pkg.sv -----
// Shared types, codes and arithmetic helpers for the sensor frame CRC converter.
package sfcc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within the six-byte response
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TEMP_CRC = 2'd1;
  localparam logic [1:0] ST_HUM_CRC  = 2'd2;

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUM_SPAN    = 14'd12500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] temperature_word;
    logic [15:0] humidity_word;
  } frame_rec_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: one estimate, one correction
  function automatic logic [15:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[30:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    return {1'b0, q0} + ((r >= FULL_SCALE) ? 16'd1 : 16'd0);
  endfunction

endpackage

// ----- hdl/sfcc_frame.sv -----
// Byte assembler and CRC-8 checker for the six-byte measurement response.
module sfcc_frame import sfcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  output logic             rec_valid,
  output frame_rec_t       rec
);

  logic [2:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] held_temperature, held_temperature_next;
  logic [15:0] held_humidity, held_humidity_next;
  logic        temperature_crc_good, temperature_crc_good_next;
  logic [2:0]  pos;
  logic [7:0]  crc_in;
  logic [7:0]  crc_upd;
  logic        hum_good;

  // A start mark or an impossible position restarts the frame at this byte
  assign pos     = (frame_start || byte_position > POS_H_CRC) ? POS_T_HI : byte_position;
  assign crc_in  = (pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : running_crc;
  assign crc_upd = crc8_update(crc_in, rx_byte);
  assign hum_good = (running_crc == rx_byte);

  always_comb begin
    byte_position_next        = byte_position;
    running_crc_next          = running_crc;
    held_temperature_next     = held_temperature;
    held_humidity_next        = held_humidity;
    temperature_crc_good_next = temperature_crc_good;
    rec_valid                 = 1'b0;
    unique case (pos)
      POS_T_HI: begin
        running_crc_next      = crc_upd;
        held_temperature_next = {rx_byte, held_temperature[7:0]};
        byte_position_next    = POS_T_LO;
      end
      POS_T_LO: begin
        running_crc_next      = crc_upd;
        held_temperature_next = {held_temperature[15:8], rx_byte};
        byte_position_next    = POS_T_CRC;
      end
      POS_T_CRC: begin
        temperature_crc_good_next = (running_crc == rx_byte);
        running_crc_next          = CRC_INIT;
        byte_position_next        = POS_H_HI;
      end
      POS_H_HI: begin
        running_crc_next   = crc_upd;
        held_humidity_next = {rx_byte, held_humidity[7:0]};
        byte_position_next = POS_H_LO;
      end
      POS_H_LO: begin
        running_crc_next   = crc_upd;
        held_humidity_next = {held_humidity[15:8], rx_byte};
        byte_position_next = POS_H_CRC;
      end
      default: begin
        running_crc_next   = CRC_INIT;
        byte_position_next = POS_T_HI;
        rec_valid          = take;
      end
    endcase
  end

  always_comb begin
    rec.temperature_word = held_temperature;
    rec.humidity_word    = held_humidity;
    if (!temperature_crc_good) begin
      rec.status = ST_TEMP_CRC;
    end else if (!hum_good) begin
      rec.status = ST_HUM_CRC;
    end else begin
      rec.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= POS_T_HI;
      running_crc          <= CRC_INIT;
      held_temperature     <= '0;
      held_humidity        <= '0;
      temperature_crc_good <= 1'b0;
    end else if (take) begin
      byte_position        <= byte_position_next;
      running_crc          <= running_crc_next;
      held_temperature     <= held_temperature_next;
      held_humidity        <= held_humidity_next;
      temperature_crc_good <= temperature_crc_good_next;
    end
  end

endmodule

// ----- hdl/sfcc_scale.sv -----
// Two-stage conversion of the raw words to hundredths, with the output register.
module sfcc_scale import sfcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  input  frame_rec_t         rec,
  output logic               rec_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [15:0]        temperature_word,
  output logic [15:0]        humidity_word
);

  logic        advance;
  logic        s1_valid;
  frame_rec_t  s1_rec;
  logic [30:0] s1_temp_prod;
  logic [29:0] s1_hum_prod;
  logic [15:0] temp_q;
  logic [15:0] hum_q;
  logic [15:0] temp_val;
  logic [13:0] hum_val;

  assign advance   = !out_valid || out_ready;
  assign rec_ready = !s1_valid || advance;

  // Stage 1: constant products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rec_ready) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) begin
      s1_rec       <= rec;
      s1_temp_prod <= 31'(rec.temperature_word) * 31'(TEMP_SPAN);
      s1_hum_prod  <= 30'(rec.humidity_word) * 30'(HUM_SPAN);
    end
  end

  // Stage 2: divide by full scale, offset and clamp
  assign temp_q   = div_full_scale(s1_temp_prod);
  assign hum_q    = div_full_scale({1'b0, s1_hum_prod});
  assign temp_val = temp_q - TEMP_OFFSET;

  always_comb begin
    if (hum_q[13:0] < HUM_OFFSET) begin
      hum_val = '0;
    end else if (hum_q[13:0] - HUM_OFFSET > HUM_MAX) begin
      hum_val = HUM_MAX;
    end else begin
      hum_val = hum_q[13:0] - HUM_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      status           <= s1_rec.status;
      temperature_word <= s1_rec.temperature_word;
      humidity_word    <= s1_rec.humidity_word;
      if (s1_rec.status == ST_OK) begin
        temperature_centi <= temp_val[14:0];
        humidity_centi    <= hum_val;
      end else begin
        temperature_centi <= '0;
        humidity_centi    <= '0;
      end
    end
  end

endmodule

// ----- hdl/sensor_frame_crc_convert.sv -----
// Top level of the sensor frame CRC checker and converter.
// Takes the six-byte humidity/temperature response one byte per beat (temperature
// word, its CRC-8, humidity word, its CRC-8; polynomial 0x31, init 0xFF) and gives
// one result per frame: status, temperature and humidity in hundredths, raw words.
// A byte is accepted every cycle while the result side keeps up; the rate is set by
// the combinational CRC byte update in the frame stage. The product register loads
// at the edge that accepts the sixth byte, and the output register loads from it
// once the output side can advance, which makes the result valid. Input stalls only
// when both the product stage and the output register hold a waiting result.
// frame_start on a byte restarts the frame there and drops any partial frame.
module sensor_frame_crc_convert import sfcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi,
  output logic [15:0]        temperature_word,
  output logic [15:0]        humidity_word
);

  logic       take;
  logic       rec_valid;
  frame_rec_t rec;

  assign take = in_valid && in_ready;

  sfcc_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  sfcc_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .rec_valid         (rec_valid),
    .rec               (rec),
    .rec_ready         (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .temperature_word  (temperature_word),
    .humidity_word     (humidity_word)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> temperature_centi == 0 && humidity_centi == 0)
    else $error("failed frame carries converted values");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_centi <= HUM_MAX
                  && (status == ST_OK || status == ST_TEMP_CRC || status == ST_HUM_CRC))
    else $error("humidity out of range or bad status code");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> temperature_centi >= -15'sd4500
                                     && temperature_centi <= 15'sd13000)
    else $error("temperature out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

// ----- test/tb_sensor_frame_crc_convert.sv -----
// Self-checking testbench for the sensor frame CRC checker and converter.
`timescale 1ns / 100ps

module tb_sensor_frame_crc_convert import sfcc_pkg::*; ();

  typedef struct {
    logic [1:0]         status;
    logic signed [14:0] temperature;
    logic [13:0]        humidity;
    logic [15:0]        temperature_raw;
    logic [15:0]        humidity_raw;
  } reading_t;

  typedef struct {
    logic [7:0] data;
    logic       first;
    bit         typed;
    reading_t   reading;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               frame_start;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [15:0]        temperature_word;
  logic [15:0]        humidity_word;

  // Decoder image: position, running CRC, words being assembled, temperature check
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [15:0] temp_raw_acc;
  logic [15:0] hum_raw_acc;
  logic        temp_crc_ok;

  reading_t  pending_readings[$];
  stim_row_t directed_rows[$];
  int        error_count;
  int        bytes_sent;
  bit        quiet;

  sensor_frame_crc_convert dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .frame_start       (frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .temperature_word  (temperature_word),
    .humidity_word     (humidity_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] crc_step(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  function automatic int idle_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the decoder image by one byte; a reading comes out on the sixth byte
  task automatic decode_frame_byte(input logic [7:0] b, input logic first,
                                   output bit got, output reading_t rd);
    logic [2:0]         p;
    logic               hum_crc_ok;
    longint unsigned    q;
    longint             tc;
    longint             hc;
    got = 1'b0;
    rd  = '{default: '0};
    p   = frame_pos;
    if (first || p > POS_H_CRC) begin
      p       = POS_T_HI;
      crc_acc = CRC_INIT;
    end
    case (p)
      POS_T_HI: begin
        crc_acc            = crc_step(CRC_INIT, b);
        temp_raw_acc[15:8] = b;
        frame_pos          = POS_T_LO;
      end
      POS_T_LO: begin
        crc_acc           = crc_step(crc_acc, b);
        temp_raw_acc[7:0] = b;
        frame_pos         = POS_T_CRC;
      end
      POS_T_CRC: begin
        temp_crc_ok = (crc_acc == b);
        crc_acc     = CRC_INIT;
        frame_pos   = POS_H_HI;
      end
      POS_H_HI: begin
        crc_acc           = crc_step(CRC_INIT, b);
        hum_raw_acc[15:8] = b;
        frame_pos         = POS_H_LO;
      end
      POS_H_LO: begin
        crc_acc          = crc_step(crc_acc, b);
        hum_raw_acc[7:0] = b;
        frame_pos        = POS_H_CRC;
      end
      default: begin
        hum_crc_ok = (crc_acc == b);
        crc_acc    = CRC_INIT;
        frame_pos  = POS_T_HI;
        got        = 1'b1;
        rd.temperature_raw = temp_raw_acc;
        rd.humidity_raw    = hum_raw_acc;
        if (!temp_crc_ok) rd.status = ST_TEMP_CRC;
        else if (!hum_crc_ok) rd.status = ST_HUM_CRC;
        else rd.status = ST_OK;
        if (rd.status == ST_OK) begin
          q  = (64'd17500 * temp_raw_acc) / 64'd65535;
          tc = longint'(q) - 4500;
          q  = (64'd12500 * hum_raw_acc) / 64'd65535;
          hc = longint'(q) - 600;
          if (hc < 0) hc = 0;
          if (hc > 10000) hc = 10000;
          rd.temperature = tc[14:0];
          rd.humidity    = hc[13:0];
        end
      end
    endcase
  endtask

  // Offer one beat from the falling edge and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic first,
                           output bit got, output reading_t rd);
    int gap;
    @(negedge clk);
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    rx_byte     = b;
    frame_start = first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_frame_byte(b, first, got, rd);
    bytes_sent++;
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic first);
    bit       got;
    reading_t rd;
    send_byte(b, first, got, rd);
    if (got) pending_readings.push_back(rd);
  endtask

  // Send the first n bytes of a frame, with either CRC spoilt on request
  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                            input bit temp_bad, input bit hum_bad, input int n);
    logic [7:0] frame_bytes[6];
    logic       first;
    frame_bytes[0] = tw[15:8];
    frame_bytes[1] = tw[7:0];
    frame_bytes[2] = word_crc(tw) ^ (temp_bad ? 8'($urandom_range(1, 255)) : 8'h00);
    frame_bytes[3] = hw[15:8];
    frame_bytes[4] = hw[7:0];
    frame_bytes[5] = word_crc(hw) ^ (hum_bad ? 8'($urandom_range(1, 255)) : 8'h00);
    // a frame may go unmarked only where the decoder already expects a first byte
    first = (frame_pos != POS_T_HI) ? 1'b1 : 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      send_predicted(frame_bytes[i], (i == 0) ? first : 1'b0);
    end
  endtask

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'h0000;
    if (r < 8) return 16'hFFFF;
    if (r < 12) return 16'($urandom_range(0, 4000));
    if (r < 16) return 16'($urandom_range(58000, 65535));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic add_row(input logic [7:0] b, input logic first);
    stim_row_t row;
    row.data    = b;
    row.first   = first;
    row.typed   = 1'b0;
    row.reading = '{default: '0};
    directed_rows.push_back(row);
  endtask

  task automatic type_reading(input logic [1:0] st, input int tc, input int hc,
                              input logic [15:0] tw, input logic [15:0] hw);
    int last;
    last = directed_rows.size() - 1;
    directed_rows[last].typed                   = 1'b1;
    directed_rows[last].reading.status          = st;
    directed_rows[last].reading.temperature     = 15'(tc);
    directed_rows[last].reading.humidity        = 14'(hc);
    directed_rows[last].reading.temperature_raw = tw;
    directed_rows[last].reading.humidity_raw    = hw;
  endtask

  // Receiver: mostly ready, occasional stalls of random length
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 9) == 0) hold = idle_cycles();
      end
    end
  end

  always @(posedge clk) begin
    reading_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: reading with nothing expected (status %0d)", $time, status);
        error_count++;
      end else begin
        e = pending_readings.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d got %0d", $time, e.status, status);
          error_count++;
        end
        if (temperature_centi !== e.temperature) begin
          $display("%0t: temperature_centi expected %0d got %0d", $time,
                   e.temperature, temperature_centi);
          error_count++;
        end
        if (humidity_centi !== e.humidity) begin
          $display("%0t: humidity_centi expected %0d got %0d", $time,
                   e.humidity, humidity_centi);
          error_count++;
        end
        if (temperature_word !== e.temperature_raw) begin
          $display("%0t: temperature_word expected %h got %h", $time,
                   e.temperature_raw, temperature_word);
          error_count++;
        end
        if (humidity_word !== e.humidity_raw) begin
          $display("%0t: humidity_word expected %h got %h", $time,
                   e.humidity_raw, humidity_word);
          error_count++;
        end
      end
    end
  end

  initial begin
    bit       got;
    reading_t rd;
    int       r;
    rst          = 1'b1;
    in_valid     = 1'b0;
    rx_byte      = 8'h00;
    frame_start  = 1'b0;
    error_count  = 0;
    bytes_sent   = 0;
    quiet        = 1'b0;
    frame_pos    = POS_T_HI;
    crc_acc      = CRC_INIT;
    temp_raw_acc = 16'h0000;
    hum_raw_acc  = 16'h0000;
    temp_crc_ok  = 1'b0;

    // Lowest words: coldest reading, humidity clamped up to zero
    add_row(8'h00, 1'b1); add_row(8'h00, 1'b0); add_row(word_crc(16'h0000), 1'b0);
    add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(word_crc(16'h0000), 1'b0);
    type_reading(ST_OK, -4500, 0, 16'h0000, 16'h0000);
    // Highest words with no start mark: hottest reading, humidity clamped down
    add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0); add_row(word_crc(16'hFFFF), 1'b0);
    add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0); add_row(word_crc(16'hFFFF), 1'b0);
    type_reading(ST_OK, 13000, 10000, 16'hFFFF, 16'hFFFF);
    // Both CRCs bad: the temperature failure wins
    add_row(8'h12, 1'b1); add_row(8'h34, 1'b0); add_row(~word_crc(16'h1234), 1'b0);
    add_row(8'h56, 1'b0); add_row(8'h78, 1'b0); add_row(~word_crc(16'h5678), 1'b0);
    type_reading(ST_TEMP_CRC, 0, 0, 16'h1234, 16'h5678);
    // Partial frame dropped by a fresh start, then a humidity CRC failure
    add_row(8'h99, 1'b1); add_row(8'h88, 1'b0);
    add_row(8'hAB, 1'b1); add_row(8'hCD, 1'b0); add_row(word_crc(16'hABCD), 1'b0);
    add_row(8'hEF, 1'b0); add_row(8'h01, 1'b0); add_row(word_crc(16'hEF01) ^ 8'h80, 1'b0);
    type_reading(ST_HUM_CRC, 0, 0, 16'hABCD, 16'hEF01);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].first, got, rd);
      if (got) pending_readings.push_back(directed_rows[i].typed ? directed_rows[i].reading : rd);
    end

    while (bytes_sent < 1950) begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_frame(pick_word(), pick_word(), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0, 6);
      end else if (r < 92) begin
        send_frame(pick_word(), pick_word(), 1'b0, 1'b0, $urandom_range(1, 5));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_predicted(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
